// ===== design/sar_pkg.sv =====
// Shared types, codes and character classes for the shell argument requoter.
package sar_pkg;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Result kinds
  localparam logic [1:0] RES_BYTE = 2'd0;
  localparam logic [1:0] RES_EOA  = 2'd1;
  localparam logic [1:0] RES_EOL  = 2'd2;

  // Characters with a role of their own
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Most results a single input item can cause
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Unquoted whitespace: tab through carriage return, and space
  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  // Characters that get a backslash inside quotes; the core handles a quoted newline first
  function automatic logic is_special(input logic [7:0] c);
    return c inside {8'h22, 8'h21, 8'h23, 8'h24, 8'h26, 8'h2A, 8'h28, 8'h29,
                     8'h5C, 8'h7C, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E,
                     8'h3F, 8'h27, 8'h60, 8'h7E, 8'h5E, 8'h3B, 8'h20, 8'h09,
                     8'h0A};
  endfunction

endpackage

// ===== design/shell_argument_requoter_core.sv =====
// Shell argument requoter: splits a byte stream into requoted arguments.
// The results of an item pass through the run register and then the output register.
// Items are taken one per cycle while each gives at most one result and the output is
// not stalled; an item that gives several results holds the next item until the single
// output register has drained its run, one result per cycle while not stalled.
// Reset clears the quote and argument flags, the result run and the output.
module shell_argument_requoter_core
  import sar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Parsing state
  logic sq_r, sq_nxt;
  logic dq_r, dq_nxt;
  logic esc_r, esc_nxt;
  logic in_arg_r, in_arg_nxt;
  logic seen_r, seen_nxt;

  // Result run waiting to drain, and the output register
  out_item_t   run_r [MAX_RESULTS];
  out_item_t   run_nxt [MAX_RESULTS];
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic        out_load;
  logic        run_busy;
  logic        run_last;
  logic        drain;

  // Step results for the incoming item
  logic [1:0]  n_res;
  logic [1:0]  rk [MAX_RESULTS];
  logic [7:0]  rb [MAX_RESULTS];
  logic [7:0]  c;

  // Handshake
  assign run_busy = (cnt_r != 2'd0);
  assign run_last = (idx_r == cnt_r - 2'd1);
  assign out_load = !out_valid_r || !out_stall;
  assign drain    = run_busy && out_load;
  assign in_stall = run_busy && !(run_last && out_load);
  assign in_fire  = in_valid && !in_stall;
  assign c        = in_data.char_byte;

  // Decode one item: results and next flags
  always_comb begin
    sq_nxt     = sq_r;
    dq_nxt     = dq_r;
    esc_nxt    = esc_r;
    in_arg_nxt = in_arg_r;
    seen_nxt   = seen_r;
    n_res      = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rk[i] = RES_BYTE;
      rb[i] = 8'd0;
    end
    if (in_data.item_kind == KIND_EOS) begin
      if (in_arg_r || !seen_r) begin
        rk[0] = RES_EOA;
        rk[1] = RES_EOL;
        n_res = 2'd2;
      end else begin
        rk[0] = RES_EOL;
        n_res = 2'd1;
      end
      sq_nxt     = 1'b0;
      dq_nxt     = 1'b0;
      esc_nxt    = 1'b0;
      in_arg_nxt = 1'b0;
      seen_nxt   = 1'b0;
    end else if (esc_r) begin
      rb[0]   = c;
      n_res   = 2'd1;
      esc_nxt = 1'b0;
    end else if (is_space(c) && !sq_r && !dq_r) begin
      if (in_arg_r) begin
        rk[0]      = RES_EOA;
        n_res      = 2'd1;
        in_arg_nxt = 1'b0;
        seen_nxt   = 1'b1;
      end
    end else if (c == CH_BACKSLASH && !sq_r) begin
      in_arg_nxt = 1'b1;
      rb[0]      = CH_BACKSLASH;
      n_res      = 2'd1;
      esc_nxt    = 1'b1;
    end else if (sq_r || dq_r) begin
      if (sq_r && c == CH_SQUOTE) begin
        sq_nxt = 1'b0;
      end else if (!sq_r && c == CH_DQUOTE) begin
        dq_nxt = 1'b0;
      end else if (c == CH_NEWLINE) begin
        rb[0] = CH_SQUOTE;
        rb[1] = CH_NEWLINE;
        rb[2] = CH_SQUOTE;
        n_res = 2'd3;
      end else if (is_special(c)) begin
        rb[0] = CH_BACKSLASH;
        rb[1] = c;
        n_res = 2'd2;
      end else begin
        rb[0] = c;
        n_res = 2'd1;
      end
    end else begin
      in_arg_nxt = 1'b1;
      if (c == CH_SQUOTE) begin
        sq_nxt = 1'b1;
      end else if (c == CH_DQUOTE) begin
        dq_nxt = 1'b1;
      end else begin
        rb[0] = c;
        n_res = 2'd1;
      end
    end
  end

  // Advance the run: drain one result, load a new run on a transfer that gives results
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      run_nxt[i] = run_r[i];
    end
    if (drain) begin
      if (run_last) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (in_fire && n_res != 2'd0) begin
      cnt_nxt = n_res;
      idx_nxt = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        run_nxt[i].result_kind = rk[i];
        run_nxt[i].out_byte    = rb[i];
        run_nxt[i].last_of_run = (2'(i) == n_res - 2'd1);
      end
    end
  end

  // Load the output register from the head of the run
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = run_busy;
      out_data_nxt  = run_r[idx_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= 1'b0;
      dq_r        <= 1'b0;
      esc_r       <= 1'b0;
      in_arg_r    <= 1'b0;
      seen_r      <= 1'b0;
      cnt_r       <= 2'd0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        sq_r     <= sq_nxt;
        dq_r     <= dq_nxt;
        esc_r    <= esc_nxt;
        in_arg_r <= in_arg_nxt;
        seen_r   <= seen_nxt;
      end
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      run_r[i] <= run_nxt[i];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/sar_checker.sv =====
// Port-level checker for the shell argument requoter, bound to the top level.
module sar_checker
  import sar_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // End of list always closes the run of its item
  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RES_EOL |-> out_data.last_of_run)
    else $error("end of list not marked last");

  // Marks carry a zero byte and a known kind
  a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != RES_BYTE |->
      out_data.out_byte == 8'd0 &&
      (out_data.result_kind == RES_EOA || out_data.result_kind == RES_EOL))
    else $error("bad mark result");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled input transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed or dropped");

endmodule

bind shell_argument_requoter_core sar_checker u_sar_checker (.*);
